// File: rtl/dlf_pkg.sv
// Shared types, codes and helper functions of the dump line formatter.
package dlf_pkg;

	localparam int ITEM_W = 32;
	localparam int OFS_W = 32;
	localparam int CHAR_W = 7;

	localparam logic [2:0] MODE_HEXB = 3'd0;
	localparam logic [2:0] MODE_CHAR = 3'd1;
	localparam logic [2:0] MODE_DEC = 3'd2;
	localparam logic [2:0] MODE_OCT = 3'd3;
	localparam logic [2:0] MODE_HEXW = 3'd4;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_START = 1'b1;

	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_END = 1'b1;

	localparam logic [4:0] BYTES_PER_LINE = 5'd16;
	localparam logic [4:0] WORDS_PER_LINE = 5'd4;
	localparam logic [OFS_W-1:0] BYTE_STEP = 32'd1;
	localparam logic [OFS_W-1:0] WORD_STEP = 32'd4;

	localparam logic [2:0] OFS_LAST_DIGIT = 3'd7;
	localparam logic [4:0] DEC_LAST_ITER = 5'd31;
	localparam int BCD_DIGITS = 10;
	localparam logic [3:0] DEC_LEFT_POS = 4'd10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_SP = 7'h20;
	localparam logic [CHAR_W-1:0] CH_NL = 7'h0a;
	localparam logic [CHAR_W-1:0] CH_BSL = 7'h5c;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CH_LA = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LB = 7'h62;
	localparam logic [CHAR_W-1:0] CH_LF = 7'h66;
	localparam logic [CHAR_W-1:0] CH_LN = 7'h6e;
	localparam logic [CHAR_W-1:0] CH_LR = 7'h72;
	localparam logic [CHAR_W-1:0] CH_LT = 7'h74;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7e;

	typedef struct packed {
		logic data;
		logic nl;
		logic hdr;
		logic [2:0] mode;
		logic [OFS_W-1:0] offset;
		logic [ITEM_W-1:0] value;
	} cmd_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
		logic [CHAR_W-1:0] c;
		if (n < 4'd10) begin
			c = CH_ZERO + {3'b000, n};
		end else begin
			c = CH_LA + {3'b000, n - 4'd10};
		end
		return c;
	endfunction

	function automatic logic [3:0] fld_len(input logic [2:0] mode);
		logic [3:0] n;
		case (mode)
			MODE_HEXB: n = 4'd3;
			MODE_CHAR: n = 4'd3;
			MODE_DEC: n = 4'd12;
			MODE_OCT: n = 4'd12;
			default: n = 4'd9;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/dlf_front.sv
// Front part: accepts items, holds the offset and line state, builds commands.
module dlf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [31:0]             s_axis_tdata,
	input  logic                    s_axis_tuser,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [31:0]             cfg_data,
	output logic                    push_valid,
	input  logic                    push_ready,
	output dlf_pkg::cmd_t           push_cmd
);

	logic [2:0] mode_q;
	logic [dlf_pkg::OFS_W-1:0] start_q;
	logic [dlf_pkg::OFS_W-1:0] offset_q;
	logic [4:0] items_q;

	logic [2:0] mode_c;
	logic bytes_c;
	logic [4:0] per_line;
	logic accept;
	logic is_end;
	logic nl;
	logic hdr;

	assign mode_c = (mode_q > dlf_pkg::MODE_HEXW) ? dlf_pkg::MODE_HEXW : mode_q;
	assign bytes_c = (mode_c == dlf_pkg::MODE_HEXB) || (mode_c == dlf_pkg::MODE_CHAR);
	assign per_line = bytes_c ? dlf_pkg::BYTES_PER_LINE : dlf_pkg::WORDS_PER_LINE;
	assign is_end = (s_axis_tuser == dlf_pkg::REQ_END);

	assign s_axis_tready = push_ready;
	assign accept = s_axis_tvalid && push_ready;

	assign nl = is_end ? (items_q != 5'd0) : (items_q >= per_line);
	assign hdr = !is_end && ((items_q == 5'd0) || nl);

	assign push_valid = accept && (!is_end || nl);
	assign push_cmd.data = !is_end;
	assign push_cmd.nl = nl;
	assign push_cmd.hdr = hdr;
	assign push_cmd.mode = mode_c;
	assign push_cmd.offset = offset_q;
	assign push_cmd.value = s_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dlf_pkg::MODE_HEXW;
			start_q <= '0;
			offset_q <= '0;
			items_q <= '0;
		end else begin
			if (accept) begin
				if (is_end) begin
					items_q <= '0;
					offset_q <= start_q;
				end else begin
					items_q <= (nl ? 5'd0 : items_q) + 5'd1;
					offset_q <= offset_q + (bytes_c ? dlf_pkg::BYTE_STEP : dlf_pkg::WORD_STEP);
				end
			end
			if (cfg_we) begin
				if (cfg_index == dlf_pkg::REG_MODE) begin
					mode_q <= cfg_data[2:0];
				end else begin
					start_q <= cfg_data;
					offset_q <= cfg_data;
				end
			end
		end
	end

	a_items_bound: assert property (@(posedge clk) disable iff (!arst_n)
		items_q <= dlf_pkg::BYTES_PER_LINE)
		else $error("Item count on the line ran past a full line.");

endmodule

// File: rtl/dlf_queue.sv
// Short command queue between the front and the back part.
module dlf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  dlf_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output dlf_pkg::cmd_t pop_cmd
);

	dlf_pkg::cmd_t entries_q [dlf_pkg::QUEUE_DEPTH];
	logic [dlf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dlf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dlf_pkg::QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != dlf_pkg::QCNT_W'(dlf_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = entries_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dlf_pkg::QCNT_W'(dlf_pkg::QUEUE_DEPTH))
		else $error("Queue holds more commands than it has entries.");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || (count_q == dlf_pkg::QCNT_W'(dlf_pkg::QUEUE_DEPTH))
		|| (wr_ptr_q != rd_ptr_q))
		else $error("Queue pointers disagree with the fill count.");

endmodule

// File: rtl/dlf_back.sv
// Back part: turns one command into dump characters, one per cycle while the output is ready.
module dlf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  dlf_pkg::cmd_t cmd,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [7:0]    m_axis_tdata,
	output logic          m_axis_tlast
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_NL = 3'd2;
	localparam logic [2:0] ST_OFS = 3'd3;
	localparam logic [2:0] ST_FLD = 3'd4;

	logic [2:0] state_q;
	dlf_pkg::cmd_t cur_q;
	logic [4:0] cnt_q;
	logic [31:0] mag_q;
	logic [4*dlf_pkg::BCD_DIGITS-1:0] bcd_q;
	logic out_valid_q;
	logic [dlf_pkg::CHAR_W-1:0] out_char_q;
	logic out_last_q;

	logic emitting;
	logic adv;
	logic [dlf_pkg::CHAR_W-1:0] ch;
	logic last;
	logic [3:0] len;
	logic [3:0] fcnt;
	logic [2:0] first_state;
	logic [4*dlf_pkg::BCD_DIGITS-1:0] bcd_adj;
	logic [3:0] ndig;
	logic [35:0] wv;
	logic [43:0] bcd_pad;
	logic [3:0] hex_i;
	logic [3:0] oct_i;
	logic [3:0] dec_p;
	logic [2:0] ofs_i;
	logic [7:0] b;
	logic [dlf_pkg::CHAR_W-1:0] esc;
	logic is_esc;
	logic [dlf_pkg::CHAR_W-1:0] fch;

	assign emitting = (state_q == ST_NL) || (state_q == ST_OFS) || (state_q == ST_FLD);
	assign adv = !out_valid_q || m_axis_tready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign len = dlf_pkg::fld_len(cur_q.mode);
	assign fcnt = cnt_q[3:0];
	assign wv = {4'b0000, cur_q.value};
	assign bcd_pad = {4'b0000, bcd_q};
	assign hex_i = 4'd8 - fcnt;
	assign oct_i = 4'd11 - fcnt;
	assign dec_p = dlf_pkg::DEC_LEFT_POS - (fcnt - 4'd1);
	assign ofs_i = dlf_pkg::OFS_LAST_DIGIT - cnt_q[2:0];
	assign b = cur_q.value[7:0];

	always_comb begin
		for (int i = 0; i < dlf_pkg::BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		ndig = 4'd1;
		for (int i = 1; i < dlf_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				ndig = 4'(i + 1);
			end
		end
	end

	always_comb begin
		is_esc = 1'b1;
		case (b)
			8'h00: esc = dlf_pkg::CH_ZERO;
			8'h08: esc = dlf_pkg::CH_LB;
			8'h0c: esc = dlf_pkg::CH_LF;
			8'h0a: esc = dlf_pkg::CH_LN;
			8'h0d: esc = dlf_pkg::CH_LR;
			8'h09: esc = dlf_pkg::CH_LT;
			default: begin
				esc = dlf_pkg::CH_SP;
				is_esc = 1'b0;
			end
		endcase
	end

	always_comb begin
		fch = dlf_pkg::CH_SP;
		if (fcnt != 4'd0) begin
			case (cur_q.mode)
				dlf_pkg::MODE_HEXB: begin
					fch = dlf_pkg::hex_char((fcnt == 4'd1) ? b[7:4] : b[3:0]);
				end
				dlf_pkg::MODE_CHAR: begin
					if (b inside {[dlf_pkg::PRINT_LO:dlf_pkg::PRINT_HI]}) begin
						fch = (fcnt == 4'd1) ? b[6:0] : dlf_pkg::CH_SP;
					end else if (is_esc) begin
						fch = (fcnt == 4'd1) ? dlf_pkg::CH_BSL : esc;
					end else begin
						fch = dlf_pkg::hex_char((fcnt == 4'd1) ? b[7:4] : b[3:0]);
					end
				end
				dlf_pkg::MODE_DEC: begin
					if (dec_p < ndig) begin
						fch = dlf_pkg::CH_ZERO + {3'b000, bcd_pad[4*dec_p +: 4]};
					end else if ((dec_p == ndig) && cur_q.value[31]) begin
						fch = dlf_pkg::CH_MINUS;
					end else begin
						fch = dlf_pkg::CH_SP;
					end
				end
				dlf_pkg::MODE_OCT: begin
					fch = dlf_pkg::CH_ZERO + {4'b0000, wv[3*oct_i +: 3]};
				end
				default: begin
					fch = dlf_pkg::hex_char(wv[4*hex_i +: 4]);
				end
			endcase
		end
	end

	always_comb begin
		case (state_q)
			ST_NL: begin
				ch = dlf_pkg::CH_NL;
				last = !cur_q.data;
			end
			ST_OFS: begin
				ch = dlf_pkg::hex_char(cur_q.offset[4*ofs_i +: 4]);
				last = 1'b0;
			end
			default: begin
				ch = fch;
				last = (fcnt == len - 4'd1);
			end
		endcase
	end

	always_comb begin
		if (cmd.nl) begin
			first_state = ST_NL;
		end else if (cmd.hdr) begin
			first_state = ST_OFS;
		end else begin
			first_state = ST_FLD;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cur_q <= cmd;
			mag_q <= cmd.value[31] ? 32'(~cmd.value + 32'd1) : cmd.value;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			{bcd_q, mag_q} <= {bcd_adj[4*dlf_pkg::BCD_DIGITS-2:0], mag_q, 1'b0};
		end
		if (emitting && adv) begin
			out_char_q <= ch;
			out_last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emitting && adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd_valid) begin
						if (cmd.data && cmd.mode == dlf_pkg::MODE_DEC) begin
							state_q <= ST_CONV;
						end else begin
							state_q <= first_state;
						end
					end
				end
				ST_CONV: begin
					if (cnt_q == dlf_pkg::DEC_LAST_ITER) begin
						cnt_q <= '0;
						state_q <= cur_q.nl ? ST_NL : (cur_q.hdr ? ST_OFS : ST_FLD);
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_NL: begin
					if (adv) begin
						state_q <= !cur_q.data ? ST_IDLE : ST_OFS;
					end
				end
				ST_OFS: begin
					if (adv) begin
						if (cnt_q[2:0] == dlf_pkg::OFS_LAST_DIGIT) begin
							cnt_q <= '0;
							state_q <= ST_FLD;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_FLD: begin
					if (adv) begin
						if (last) begin
							cnt_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_char_q};
	assign m_axis_tlast = out_last_q;

	a_fld_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLD) |-> (fcnt < len))
		else $error("Field position ran past the field width.");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emitting && adv && last) |=> (state_q == ST_IDLE))
		else $error("A final character did not end the command.");

endmodule

// File: rtl/dump_line_formatter_core.sv
// Top level of the dump line formatter.
// The block emits one ASCII character per cycle at most. A byte item yields three characters, a
// hex word nine, an octal or decimal word twelve, plus a newline before a new line and eight
// offset digits at its start. The back part takes each command from the queue in its idle
// state, and a decimal word first goes through bit-serial binary-to-BCD conversion of all 32
// bits before its characters. The four-entry command queue lets the input side run ahead
// of the character output. There is no clearing pass after reset.
module dump_line_formatter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // item_value[31:0]
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // text_char[6:0], zero
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic push_valid;
	logic push_ready;
	dlf_pkg::cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	dlf_pkg::cmd_t pop_cmd;

	dlf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_cmd      (push_cmd)
	);

	dlf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	dlf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (pop_valid),
		.cmd_ready     (pop_ready),
		.cmd           (pop_cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
